[hw/rtl/pisp_pkg.sv]
package pisp_pkg;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2
  } radix_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [3:0] HEX_TEN  = 4'd10;

  typedef struct packed {
    logic        ok;
    logic [3:0]  value;
  } digit_t;

endpackage

[hw/rtl/pisp_digit.sv]
module pisp_digit (
  input  logic [7:0]              char_i,
  input  pisp_pkg::radix_e        radix_i,
  output pisp_pkg::digit_t        digit_o
);
  import pisp_pkg::*;

  logic [7:0] off_num;
  logic [7:0] off_lc;
  logic [7:0] off_uc;

  assign off_num = char_i - CH_0;
  assign off_lc  = char_i - CH_LC_A;
  assign off_uc  = char_i - CH_UC_A;

  always_comb begin
    digit_o = '{ok: 1'b0, value: 4'd0};
    priority if (char_i >= CH_0 && char_i <= CH_9) begin
      digit_o.value = off_num[3:0];
      digit_o.ok    = (radix_i != RX_BIN) || (char_i <= CH_1);
    end else if (radix_i == RX_HEX && char_i >= CH_LC_A && char_i <= CH_LC_F) begin
      digit_o.value = off_lc[3:0] + HEX_TEN;
      digit_o.ok    = 1'b1;
    end else if (radix_i == RX_HEX && char_i >= CH_UC_A && char_i <= CH_UC_F) begin
      digit_o.value = off_uc[3:0] + HEX_TEN;
      digit_o.ok    = 1'b1;
    end else begin
      digit_o.ok    = 1'b0;
    end
  end

endmodule

[hw/rtl/pisp_core.sv]
module pisp_core #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  char_i,
  output logic [31:0] value_o,
  output logic        status_o
);
  import pisp_pkg::*;

  phase_e                 phase_q, phase_d;
  radix_e                 radix_q, radix_d;
  logic                   neg_q, neg_d;
  logic                   err_q, err_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;

  digit_t                 dig;
  logic [VALUE_WIDTH-1:0] acc_scaled;
  logic [VALUE_WIDTH-1:0] acc_next;
  logic signed [VALUE_WIDTH-1:0] final_v;

  pisp_digit u_digit (
    .char_i  (char_i),
    .radix_i (radix_q),
    .digit_o (dig)
  );

  always_comb begin
    unique case (radix_q)
      RX_HEX:  acc_scaled = acc_q << 4;
      RX_BIN:  acc_scaled = acc_q << 1;
      default: acc_scaled = (acc_q << 3) + (acc_q << 1);
    endcase
  end

  assign acc_next = acc_scaled + VALUE_WIDTH'(dig.value);

  always_comb begin
    if (err_q) begin
      final_v = '0;
    end else if (neg_q) begin
      final_v = VALUE_WIDTH'(0) - acc_q;
    end else begin
      final_v = acc_q;
    end
  end

  assign value_o  = 32'(final_v);
  assign status_o = err_q;

  always_comb begin
    phase_d = phase_q;
    radix_d = radix_q;
    neg_d   = neg_q;
    err_d   = err_q;
    acc_d   = acc_q;
    if (char_i == CH_NUL) begin
      phase_d = PH_START;
      radix_d = RX_DEC;
      neg_d   = 1'b0;
      err_d   = 1'b0;
      acc_d   = '0;
    end else if (!err_q) begin
      unique case (phase_q)
        PH_START: begin
          priority if (char_i == CH_MINUS) begin
            neg_d   = 1'b1;
            phase_d = PH_SIGN;
          end else if (char_i == CH_0) begin
            phase_d = PH_ZERO;
          end else if (dig.ok) begin
            acc_d   = acc_next;
            phase_d = PH_DIGITS;
          end else begin
            err_d   = 1'b1;
          end
        end
        PH_SIGN: begin
          priority if (char_i == CH_0) begin
            phase_d = PH_ZERO;
          end else if (dig.ok) begin
            acc_d   = acc_next;
            phase_d = PH_DIGITS;
          end else begin
            err_d   = 1'b1;
          end
        end
        PH_ZERO: begin
          priority if (char_i == CH_LC_X) begin
            radix_d = RX_HEX;
            phase_d = PH_DIGITS;
          end else if (char_i == CH_LC_B) begin
            radix_d = RX_BIN;
            phase_d = PH_DIGITS;
          end else if (dig.ok) begin
            acc_d   = acc_next;
            phase_d = PH_DIGITS;
          end else begin
            err_d   = 1'b1;
          end
        end
        default: begin
          if (dig.ok) begin
            acc_d = acc_next;
          end else begin
            err_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      radix_q <= RX_DEC;
      neg_q   <= 1'b0;
      err_q   <= 1'b0;
      acc_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      radix_q <= radix_d;
      neg_q   <= neg_d;
      err_q   <= err_d;
      acc_q   <= acc_d;
    end
  end

`ifndef SYNTHESIS
  // sign seen implies we left the start phase
  a_neg_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    neg_q |-> (phase_q != PH_START))
    else $error("sign flag set in start phase");

  // a non-decimal radix only exists once digits phase is reached
  a_radix_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (radix_q != RX_DEC) |-> (phase_q == PH_DIGITS))
    else $error("radix prefix outside digits phase");

  // terminator returns to start
  a_term_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && char_i == CH_NUL) |=> (phase_q == PH_START && !err_q && acc_q == '0))
    else $error("terminator did not clear state");
`endif

endmodule

[hw/rtl/prefixed_integer_string_parser.sv]
// Prefixed integer string parser: one ASCII character per request.
// A terminator goes through the input register, then the result register.
// One character per unstalled cycle; the input register drains while a result waits.
// Stall: only a terminator waits, when the result register is still full.
// Reset (async, active low) clears the parse state and both valid flags.
module prefixed_integer_string_parser #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value
  output logic        m_axis_tuser    // [0] status
);
  import pisp_pkg::*;

  logic        in_vld_q;
  logic [7:0]  in_char_q;
  logic        out_vld_q, out_vld_d;
  logic [31:0] out_value_q;
  logic        out_status_q;

  logic        consume;
  logic        is_term;
  logic [31:0] core_value;
  logic        core_status;

  assign is_term       = (in_char_q == CH_NUL);
  assign consume       = in_vld_q && (!is_term || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
    end
  end

  pisp_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (consume),
    .char_i   (in_char_q),
    .value_o  (core_value),
    .status_o (core_status)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (consume && is_term) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && is_term) begin
      out_value_q  <= core_value;
      out_status_q <= core_status;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

`ifndef SYNTHESIS
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !is_term && !out_vld_q) |=> !out_vld_q)
    else $error("result produced without terminator");

  a_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && is_term && out_vld_q))
    else $error("input stalled without full result register");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q) |-> (out_value_q == 32'd0))
    else $error("error result carries nonzero value");
`endif

endmodule
